@@ hdl/tct_pkg.sv @@
package tct_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned FLAGS_W = 8;
  localparam int unsigned OUT_CNT_W = 32;

  localparam logic [FLAGS_W-1:0] FL_FIN  = 8'h01;
  localparam logic [FLAGS_W-1:0] FL_SYN  = 8'h02;
  localparam logic [FLAGS_W-1:0] FL_RST  = 8'h04;
  localparam logic [FLAGS_W-1:0] FL_ACK  = 8'h10;
  localparam logic [FLAGS_W-1:0] FL_MASK = FL_FIN | FL_SYN | FL_RST | FL_ACK;

  localparam logic [TIME_W-1:0] TIME_WAIT_DEFAULT = 64'd120000000;

  // Configuration register indexes.
  localparam logic CFG_CREATION_TIME = 1'b0;
  localparam logic CFG_TIME_WAIT     = 1'b1;

  typedef enum logic [2:0] {
    PH_REQUESTED   = 3'd0,
    PH_ESTABLISHED = 3'd1,
    PH_DATA        = 3'd2,
    PH_CLOSING     = 3'd3,
    PH_CLOSED      = 3'd4,
    PH_FAILURE     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CLS_ACK,
    CLS_SYN,
    CLS_SYNACK,
    CLS_FIN,
    CLS_RST,
    CLS_OTHER
  } flag_cls_t;

  typedef struct packed {
    logic              direction;
    flag_cls_t         cls;
    logic              in_window;
    logic [TIME_W-1:0] packet_time;
  } tct_entry_t;

endpackage

@@ hdl/tct_front.sv @@
module tct_front import tct_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [TIME_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_direction,
  input  logic [FLAGS_W-1:0]  in_tcp_flags,
  input  logic [TIME_W-1:0]   in_packet_time,
  input  logic                q_full,
  output logic                q_push,
  output tct_entry_t          q_entry
);

  logic [TIME_W-1:0] creation_time_r, creation_time_nxt;
  logic [TIME_W-1:0] time_wait_r, time_wait_nxt;
  logic [FLAGS_W-1:0] flags_m;
  logic [TIME_W-1:0] since_creation;
  flag_cls_t cls;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~q_full;
  assign q_push    = in_valid & ~q_full;

  always_comb begin
    creation_time_nxt = creation_time_r;
    time_wait_nxt     = time_wait_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_CREATION_TIME: creation_time_nxt = cfg_wdata;
        CFG_TIME_WAIT:     time_wait_nxt     = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      creation_time_r <= '0;
      time_wait_r     <= TIME_WAIT_DEFAULT;
    end else begin
      creation_time_r <= creation_time_nxt;
      time_wait_r     <= time_wait_nxt;
    end
  end

  assign flags_m = in_tcp_flags & FL_MASK;

  always_comb begin
    case (flags_m)
      FL_ACK:                cls = CLS_ACK;
      FL_SYN:                cls = CLS_SYN;
      FL_SYN | FL_ACK:       cls = CLS_SYNACK;
      FL_FIN, FL_FIN|FL_ACK: cls = CLS_FIN;
      FL_RST, FL_RST|FL_ACK: cls = CLS_RST;
      default:               cls = CLS_OTHER;
    endcase
  end

  // In the data phase a retransmitted handshake needs a known creation time.
  assign since_creation = in_packet_time - creation_time_r;

  always_comb begin
    q_entry.direction   = in_direction;
    q_entry.cls         = cls;
    q_entry.in_window   = (creation_time_r != '0) &&
                          ((in_packet_time <= creation_time_r) ||
                           (since_creation <= time_wait_r));
    q_entry.packet_time = in_packet_time;
  end

endmodule

@@ hdl/tct_fifo.sv @@
module tct_fifo import tct_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tct_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output tct_entry_t head_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  tct_entry_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hdl/tct_back.sv @@
module tct_back import tct_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  tct_entry_t           q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_accepted,
  output logic [2:0]           out_conn_state,
  output logic                 out_closer_side,
  output logic [TIME_W-1:0]    out_last_packet_time,
  output logic [OUT_CNT_W-1:0] out_client_packet_count,
  output logic [OUT_CNT_W-1:0] out_server_packet_count
);

  logic                   out_valid_r, out_valid_nxt;
  logic                   accepted_r, accepted_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   closer_r, closer_nxt;
  logic [TIME_W-1:0]      last_time_r, last_time_nxt;
  logic [COUNT_WIDTH-1:0] client_cnt_r, client_cnt_nxt;
  logic [COUNT_WIDTH-1:0] server_cnt_r, server_cnt_nxt;
  logic [63:0]            client_ext, server_ext;
  logic                   side;
  logic                   ok;
  phase_t                 judged;

  // The state registers double as the result payload: nothing new is taken
  // from the queue while a result is still waiting.
  assign q_pop = q_valid & (~out_valid_r | out_ready);
  assign side  = q_entry.direction;

  always_comb begin
    ok         = 1'b0;
    judged     = phase_r;
    closer_nxt = closer_r;
    case (phase_r)
      PH_REQUESTED: begin
        if (q_entry.cls == CLS_SYNACK && side) begin
          ok = 1'b1; judged = PH_ESTABLISHED;
        end else if ((q_entry.cls == CLS_SYN || q_entry.cls == CLS_ACK) && !side) begin
          ok = 1'b1;
        end else if (q_entry.cls == CLS_RST) begin
          ok = 1'b1; judged = PH_CLOSED; closer_nxt = side;
        end
      end
      PH_ESTABLISHED: begin
        if (q_entry.cls == CLS_ACK && !side) begin
          ok = 1'b1; judged = PH_DATA;
        end else if ((q_entry.cls == CLS_SYN && !side) ||
                     (q_entry.cls == CLS_SYNACK && side)) begin
          ok = 1'b1;
        end else if (q_entry.cls == CLS_RST) begin
          ok = 1'b1; judged = PH_CLOSED; closer_nxt = side;
        end
      end
      PH_DATA: begin
        if (q_entry.cls == CLS_ACK) begin
          ok = 1'b1;
        end else if (q_entry.cls == CLS_FIN) begin
          ok = 1'b1; judged = PH_CLOSING; closer_nxt = side;
        end else if (q_entry.cls == CLS_RST) begin
          ok = 1'b1; judged = PH_CLOSED; closer_nxt = side;
        end else if (((q_entry.cls == CLS_SYN && !side) ||
                      (q_entry.cls == CLS_SYNACK && side)) && q_entry.in_window) begin
          ok = 1'b1;
        end
      end
      PH_CLOSING: begin
        if (q_entry.cls == CLS_ACK) begin
          ok = 1'b1;
        end else if (q_entry.cls == CLS_FIN) begin
          ok = 1'b1;
          if (side != closer_r) begin
            judged = PH_CLOSED;
          end
        end else if (q_entry.cls == CLS_RST) begin
          ok = 1'b1; judged = PH_CLOSED;
        end
      end
      PH_CLOSED: begin
        ok = (q_entry.cls == CLS_ACK) || (q_entry.cls == CLS_FIN) ||
             (q_entry.cls == CLS_RST);
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r & ~out_ready;
    accepted_nxt   = accepted_r;
    phase_nxt      = phase_r;
    last_time_nxt  = last_time_r;
    client_cnt_nxt = client_cnt_r;
    server_cnt_nxt = server_cnt_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      accepted_nxt  = ok;
      if (side) begin
        if (server_cnt_r != '1) server_cnt_nxt = server_cnt_r + 1'b1;
      end else begin
        if (client_cnt_r != '1) client_cnt_nxt = client_cnt_r + 1'b1;
      end
      if (ok) begin
        phase_nxt     = judged;
        last_time_nxt = q_entry.packet_time;
      end else begin
        phase_nxt = PH_FAILURE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      accepted_r   <= 1'b0;
      phase_r      <= PH_REQUESTED;
      closer_r     <= 1'b0;
      last_time_r  <= '0;
      client_cnt_r <= '0;
      server_cnt_r <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      accepted_r   <= accepted_nxt;
      phase_r      <= phase_nxt;
      if (q_pop) begin
        closer_r <= closer_nxt;
      end
      last_time_r  <= last_time_nxt;
      client_cnt_r <= client_cnt_nxt;
      server_cnt_r <= server_cnt_nxt;
    end
  end

  assign client_ext = 64'(client_cnt_r);
  assign server_ext = 64'(server_cnt_r);

  assign out_valid               = out_valid_r;
  assign out_accepted            = accepted_r;
  assign out_conn_state          = phase_r;
  assign out_closer_side         = closer_r;
  assign out_last_packet_time    = last_time_r;
  assign out_client_packet_count = client_ext[OUT_CNT_W-1:0];
  assign out_server_packet_count = server_ext[OUT_CNT_W-1:0];

endmodule

@@ hdl/tcp_connection_tracker_core.sv @@
// Tracks the state of one TCP connection from the packets seen on it.
// Input channel (in_*): one packet item per handshake, carrying its
// direction, flag byte and microsecond timestamp. Output channel (out_*):
// exactly one result item per packet, in order, with the verdict, the new
// connection state, the closing side, the last accepted time and the
// saturating per-direction packet counts.
// Configuration (cfg_*): index 0 is the creation time, index 1 the time-wait
// window; writes are taken every cycle and should be made while idle.
// From input acceptance to result valid, the front end classifies the packet
// and checks the time-wait window on the way into a small queue, and the back
// end updates the state and loads the result registers.
// Throughput is one item per cycle while the receiver keeps out_ready high.
// When the receiver stalls the result is held, the queue fills up to
// FIFO_DEPTH items and in_ready then drops until the result is taken.
// A synchronous reset empties the queue, clears the state and counters and
// restores the default configuration.
module tcp_connection_tracker_core import tct_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned FIFO_DEPTH  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_direction,
  input  logic [FLAGS_W-1:0]   in_tcp_flags,
  input  logic [TIME_W-1:0]    in_packet_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_accepted,
  output logic [2:0]           out_conn_state,
  output logic                 out_closer_side,
  output logic [TIME_W-1:0]    out_last_packet_time,
  output logic [OUT_CNT_W-1:0] out_client_packet_count,
  output logic [OUT_CNT_W-1:0] out_server_packet_count
);

  logic       q_full, q_push, q_pop, q_valid;
  tct_entry_t push_entry, head_entry;

  tct_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_direction   (in_direction),
    .in_tcp_flags   (in_tcp_flags),
    .in_packet_time (in_packet_time),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (push_entry)
  );

  tct_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  tct_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_valid                 (q_valid),
    .q_entry                 (head_entry),
    .q_pop                   (q_pop),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_accepted            (out_accepted),
    .out_conn_state          (out_conn_state),
    .out_closer_side         (out_closer_side),
    .out_last_packet_time    (out_last_packet_time),
    .out_client_packet_count (out_client_packet_count),
    .out_server_packet_count (out_server_packet_count)
  );

endmodule

@@ hdl/tct_checker.sv @@
module tct_checker import tct_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_accepted,
  input logic [2:0]           out_conn_state,
  input logic [TIME_W-1:0]    out_last_packet_time,
  input logic [OUT_CNT_W-1:0] out_server_packet_count
);

  logic failed_seen_r, failed_seen_nxt;

  // Remembers that a failure result has been delivered since reset.
  assign failed_seen_nxt = failed_seen_r |
                           (out_valid & out_ready & (out_conn_state == PH_FAILURE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_seen_r <= 1'b0;
    end else begin
      failed_seen_r <= failed_seen_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_conn_state) &&
                                $stable(out_last_packet_time))
    else $error("result changed while stalled");

  a_refused_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_conn_state == PH_FAILURE)
    else $error("refused item did not move the connection to failure");

  a_failure_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && failed_seen_r |-> out_conn_state == PH_FAILURE && !out_accepted)
    else $error("connection left the failure state");

  a_no_server_while_requested: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_conn_state == PH_REQUESTED |-> out_server_packet_count == '0)
    else $error("server packet seen while still requested");

endmodule

bind tcp_connection_tracker_core tct_checker u_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_accepted            (out_accepted),
  .out_conn_state          (out_conn_state),
  .out_last_packet_time    (out_last_packet_time),
  .out_server_packet_count (out_server_packet_count)
);
